>>> rtl/binary_heap_priority_queue_macros.svh
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BHPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

>>> rtl/bhpq_pkg.sv
`default_nettype none

package bhpq_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 256;
  localparam int unsigned KEY_WIDTH_DEF  = 64;
  localparam int unsigned KEY_PORT_W     = 64;
  localparam int unsigned FILL_W         = 9;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PUSH_INIT,
    OP_POP_INIT,
    OP_PEEK,
    OP_UP_READ,
    OP_UP_MOVE,
    OP_DN_READ,
    OP_DN_MOVE,
    OP_PLACE
  } dp_op_e;

  typedef struct packed {
    logic    accept;
    dp_op_e  op;
    logic    finish;
    status_e sts;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic count_full;
    logic pos_zero;
    logic up_stop;
    logic dn_stop;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/bhpq_ctrl.sv
`default_nettype none

module bhpq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic [1:0]         mode_i,
  input  wire bhpq_pkg::dp_stat_t stat_i,
  output bhpq_pkg::dp_cmd_t       cmd_o,
  output logic                    busy
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PEEK   = 3'd1;
  localparam logic [2:0] ST_POP    = 3'd2;
  localparam logic [2:0] ST_UP_RD  = 3'd3;
  localparam logic [2:0] ST_UP_CMP = 3'd4;
  localparam logic [2:0] ST_DN_RD  = 3'd5;
  localparam logic [2:0] ST_DN_CMP = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.op      = bhpq_pkg::OP_IDLE;
    cmd_o.finish  = 1'b0;
    cmd_o.sts     = bhpq_pkg::STS_OK;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          case (mode_i)
            bhpq_pkg::MODE_PUSH: begin
              if (stat_i.count_full) begin
                cmd_o.finish = 1'b1;
                cmd_o.sts    = bhpq_pkg::STS_FULL;
              end else begin
                cmd_o.op = bhpq_pkg::OP_PUSH_INIT;
                state_d  = ST_UP_RD;
              end
            end
            bhpq_pkg::MODE_POP: begin
              if (stat_i.count_zero) begin
                cmd_o.finish = 1'b1;
                cmd_o.sts    = bhpq_pkg::STS_EMPTY;
              end else begin
                state_d = ST_POP;
              end
            end
            bhpq_pkg::MODE_PEEK: begin
              if (stat_i.count_zero) begin
                cmd_o.finish = 1'b1;
                cmd_o.sts    = bhpq_pkg::STS_EMPTY;
              end else begin
                state_d = ST_PEEK;
              end
            end
            default: begin
              // The unused mode is answered at once and leaves the heap and its count unchanged.
              cmd_o.finish = 1'b1;
            end
          endcase
        end
      end
      ST_PEEK: begin
        cmd_o.op     = bhpq_pkg::OP_PEEK;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_POP: begin
        cmd_o.op = bhpq_pkg::OP_POP_INIT;
        if (stat_i.count_one) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_DN_RD;
        end
      end
      ST_UP_RD: begin
        if (stat_i.pos_zero) begin
          cmd_o.op     = bhpq_pkg::OP_PLACE;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.op = bhpq_pkg::OP_UP_READ;
          state_d  = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (stat_i.up_stop) begin
          cmd_o.op     = bhpq_pkg::OP_PLACE;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.op = bhpq_pkg::OP_UP_MOVE;
          state_d  = ST_UP_RD;
        end
      end
      ST_DN_RD: begin
        cmd_o.op = bhpq_pkg::OP_DN_READ;
        state_d  = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (stat_i.dn_stop) begin
          cmd_o.op     = bhpq_pkg::OP_PLACE;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.op = bhpq_pkg::OP_DN_MOVE;
          state_d  = ST_DN_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/bhpq_dp.sv
`default_nettype none

module bhpq_dp #(
  parameter int unsigned HEAP_DEPTH = bhpq_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH  = bhpq_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bhpq_pkg::dp_cmd_t               cmd_i,
  output bhpq_pkg::dp_stat_t                   stat_o,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_data_i,
  input  wire logic [bhpq_pkg::KEY_PORT_W-1:0] key_value_i,
  output logic      [bhpq_pkg::KEY_PORT_W-1:0] top_value_o,
  output logic      [1:0]                      status_o,
  output logic      [bhpq_pkg::FILL_W-1:0]     fill_count_o,
  output logic                                 done_o
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IW = AW + 2;

  logic [KEY_WIDTH-1:0] heap_mem [HEAP_DEPTH];

  logic [CW-1:0]        count_q;
  logic                 order_q;
  logic                 done_q;
  bhpq_pkg::status_e    status_q;
  logic [AW-1:0]        pos_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] top_q;
  logic [KEY_WIDTH-1:0] rd_a_q;
  logic [KEY_WIDTH-1:0] rd_b_q;

  logic [IW-1:0]        left_idx;
  logic [IW-1:0]        right_idx;
  logic [AW-1:0]        parent_idx;
  logic [AW-1:0]        last_idx;
  logic                 left_ok;
  logic                 right_ok;
  logic                 left_prec;
  logic                 right_prec;
  logic                 up_stop;
  logic [AW-1:0]        rd_a_addr;
  logic [AW-1:0]        rd_b_addr;
  logic                 wr_en;
  logic [KEY_WIDTH-1:0] wr_data;

  // True when key a strictly comes before key b in the selected order.
  function automatic logic precedes(input logic is_max, input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b);
    precedes = is_max ? (a > b) : (a < b);
  endfunction

  assign left_idx   = {1'b0, pos_q, 1'b1};
  assign right_idx  = {1'b0, pos_q, 1'b0} + IW'(2);
  assign parent_idx = AW'((pos_q - AW'(1)) >> 1);
  assign last_idx   = AW'(count_q - CW'(1));
  assign left_ok    = left_idx < IW'(count_q);
  assign right_ok   = right_idx < IW'(count_q);

  // Both right-child compares run in parallel; the left result picks one.
  assign left_prec  = left_ok && precedes(order_q, rd_a_q, key_q);
  assign right_prec = right_ok && (left_prec ? precedes(order_q, rd_b_q, rd_a_q)
                                             : precedes(order_q, rd_b_q, key_q));
  assign up_stop    = precedes(order_q, rd_a_q, key_q);

  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = last_idx;
    case (cmd_i.op)
      bhpq_pkg::OP_UP_READ: begin
        rd_a_addr = parent_idx;
      end
      bhpq_pkg::OP_DN_READ: begin
        rd_a_addr = left_idx[AW-1:0];
        rd_b_addr = right_idx[AW-1:0];
      end
      default: begin
        rd_a_addr = '0;
        rd_b_addr = last_idx;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = key_q;
    case (cmd_i.op)
      bhpq_pkg::OP_PLACE: begin
        wr_en = 1'b1;
      end
      bhpq_pkg::OP_UP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_a_q;
      end
      bhpq_pkg::OP_DN_MOVE: begin
        wr_en   = 1'b1;
        wr_data = right_prec ? rd_b_q : rd_a_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem[pos_q] <= wr_data;
    end
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      order_q  <= 1'b0;
      done_q   <= 1'b0;
      status_q <= bhpq_pkg::STS_OK;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish) begin
        status_q <= cmd_i.sts;
      end
      if (cfg_we_i) begin
        order_q <= cfg_data_i;
      end
      if (cmd_i.op == bhpq_pkg::OP_PUSH_INIT) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.op == bhpq_pkg::OP_POP_INIT) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      top_q <= '0;
    end
    case (cmd_i.op)
      bhpq_pkg::OP_PUSH_INIT: begin
        pos_q <= AW'(count_q);
        key_q <= key_value_i[KEY_WIDTH-1:0];
      end
      bhpq_pkg::OP_PEEK: begin
        top_q <= rd_a_q;
      end
      bhpq_pkg::OP_POP_INIT: begin
        // The last entry becomes the key that sinks from the root.
        top_q <= rd_a_q;
        key_q <= rd_b_q;
        pos_q <= '0;
      end
      bhpq_pkg::OP_UP_MOVE: begin
        pos_q <= parent_idx;
      end
      bhpq_pkg::OP_DN_MOVE: begin
        pos_q <= right_prec ? right_idx[AW-1:0] : left_idx[AW-1:0];
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
  end

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.count_one  = (count_q == CW'(1));
  assign stat_o.count_full = (count_q == CW'(HEAP_DEPTH));
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.up_stop    = up_stop;
  assign stat_o.dn_stop    = !left_prec && !right_prec;

  assign top_value_o  = bhpq_pkg::KEY_PORT_W'(top_q);
  assign status_o     = status_q;
  assign fill_count_o = bhpq_pkg::FILL_W'(count_q);
  assign done_o       = done_q;

endmodule

`default_nettype wire

>>> rtl/binary_heap_priority_queue.sv
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      mode_i, key_value_i
// result    out        done_o strobe, one cycle  top_value_o, status_o, fill_count_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (order_is_max)
//
// A push or pop walks the tree one level at a time, each level a memory read and then a
// compare with a write, from accept to the strobe; a peek only reads the root, and a
// rejected request is answered straight from idle.
// The single heap memory port set (one write, two reads) paces each level.
// Reset clears the count and the order bit; the memory itself is never cleared.
// The result cannot be stalled: the strobe lasts exactly one cycle.
`default_nettype none

`include "binary_heap_priority_queue_macros.svh"

module binary_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH = bhpq_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH  = bhpq_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [bhpq_pkg::KEY_PORT_W-1:0] key_value_i,
  output logic                                 done_o,
  output logic      [bhpq_pkg::KEY_PORT_W-1:0] top_value_o,
  output logic      [1:0]                      status_o,
  output logic      [bhpq_pkg::FILL_W-1:0]     fill_count_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic                            cfg_data_i
);

  bhpq_pkg::dp_cmd_t  cmd;
  bhpq_pkg::dp_stat_t stat;

  // The order bit only changes when no item is running or being taken.
  assign cfg_ready_o = !busy && !start;

  bhpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  bhpq_dp #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .key_value_i  (key_value_i),
    .top_value_o  (top_value_o),
    .status_o     (status_o),
    .fill_count_o (fill_count_o),
    .done_o       (done_o)
  );

  // Every item ends by returning the controller to idle.
  `BHPQ_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // A rejected push leaves a full heap.
  `BHPQ_ASSERT_SAME(a_full_count, clk_i, rst_ni, done_o && status_o == bhpq_pkg::STS_FULL,
                    fill_count_o == bhpq_pkg::FILL_W'(HEAP_DEPTH))
  // A rejected pop or peek leaves an empty heap and reports no key.
  `BHPQ_ASSERT_SAME(a_empty_count, clk_i, rst_ni, done_o && status_o == bhpq_pkg::STS_EMPTY,
                    fill_count_o == '0 && top_value_o == '0)
  // A sift-down read is never the last step of an item, so no result follows it.
  `BHPQ_ASSERT_NEXT(a_busy_no_done, clk_i, rst_ni, busy && $past(busy) && !stat.pos_zero
                    && cmd.op == bhpq_pkg::OP_DN_READ, !done_o)

endmodule

`default_nettype wire

>>> tb/binary_heap_priority_queue_test.sv
`default_nettype none

module binary_heap_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_SLOTS    = bhpq_pkg::HEAP_DEPTH_DEF;
  localparam int unsigned KEY_W         = bhpq_pkg::KEY_PORT_W;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned STALL_LIMIT   = 2000;

  typedef struct {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    int unsigned      gap;
  } request_t;

  typedef struct {
    logic [KEY_W-1:0]            top;
    logic [1:0]                  sts;
    logic [bhpq_pkg::FILL_W-1:0] fill;
  } outcome_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        start       = 1'b0;
  logic                        busy;
  logic [1:0]                  mode_i      = bhpq_pkg::MODE_PUSH;
  logic [KEY_W-1:0]            key_value_i = '0;
  logic                        done_o;
  logic [KEY_W-1:0]            top_value_o;
  logic [1:0]                  status_o;
  logic [bhpq_pkg::FILL_W-1:0] fill_count_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic                        cfg_data_i  = 1'b0;

  // Predicted heap contents and configuration.
  logic [KEY_W-1:0] heap_keys [HEAP_SLOTS];
  int unsigned      held      = 0;
  bit               max_first = 1'b0;

  request_t    pending[$];
  outcome_t    awaited[$];
  int unsigned planned_count = 0;
  bit          steady        = 1'b0;
  int unsigned gap_left      = 0;
  int unsigned quiet_cycles  = 0;

  int unsigned failures = 0;
  int unsigned checked  = 0;
  int unsigned n_push   = 0;
  int unsigned n_pop    = 0;
  int unsigned n_peek   = 0;
  int unsigned n_unused = 0;
  int unsigned n_full   = 0;
  int unsigned n_empty  = 0;
  int unsigned n_orders = 0;

  binary_heap_priority_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .key_value_i  (key_value_i),
    .done_o       (done_o),
    .top_value_o  (top_value_o),
    .status_o     (status_o),
    .fill_count_o (fill_count_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit ahead(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return max_first ? (a > b) : (a < b);
  endfunction

  function automatic void swap_slots(int unsigned i, int unsigned j);
    logic [KEY_W-1:0] t;
    t = heap_keys[i];
    heap_keys[i] = heap_keys[j];
    heap_keys[j] = t;
  endfunction

  function automatic outcome_t predict_request(logic [1:0] mode, logic [KEY_W-1:0] key);
    outcome_t    res;
    int unsigned pos;
    int unsigned up;
    int unsigned pick;
    bit          moving;
    res.top = '0;
    res.sts = bhpq_pkg::STS_OK;
    case (mode)
      bhpq_pkg::MODE_PUSH: begin
        n_push++;
        if (held >= HEAP_SLOTS) begin
          res.sts = bhpq_pkg::STS_FULL;
          n_full++;
        end else begin
          pos = held;
          heap_keys[pos] = key;
          held++;
          // A key equal to its parent keeps rising.
          moving = 1'b1;
          while (pos != 0 && moving) begin
            up = (pos - 1) / 2;
            if (ahead(heap_keys[up], heap_keys[pos])) begin
              moving = 1'b0;
            end else begin
              swap_slots(up, pos);
              pos = up;
            end
          end
        end
      end
      bhpq_pkg::MODE_POP, bhpq_pkg::MODE_PEEK: begin
        if (mode == bhpq_pkg::MODE_POP) n_pop++;
        else n_peek++;
        if (held == 0) begin
          res.sts = bhpq_pkg::STS_EMPTY;
          n_empty++;
        end else begin
          res.top = heap_keys[0];
          if (mode == bhpq_pkg::MODE_POP) begin
            held--;
            if (held > 0) begin
              heap_keys[0] = heap_keys[held];
              pos = 0;
              moving = 1'b1;
              // Only a strictly better child moves up; the left one wins ties.
              while (moving) begin
                pick = pos;
                if (2 * pos + 1 < held && ahead(heap_keys[2 * pos + 1], heap_keys[pick]))
                  pick = 2 * pos + 1;
                if (2 * pos + 2 < held && ahead(heap_keys[2 * pos + 2], heap_keys[pick]))
                  pick = 2 * pos + 2;
                if (pick == pos) begin
                  moving = 1'b0;
                end else begin
                  swap_slots(pos, pick);
                  pos = pick;
                end
              end
            end
          end
        end
      end
      default: n_unused++;
    endcase
    res.fill = bhpq_pkg::FILL_W'(held);
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] draw_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KEY_W'($urandom_range(0, 7));
      5:       return '1 - KEY_W'($urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_item(logic [1:0] mode, logic [KEY_W-1:0] key);
    request_t item;
    if ($urandom_range(0, 39) == 0) steady = !steady;
    item.mode = mode;
    item.key  = key;
    item.gap  = steady ? 0 : $urandom_range(0, 7);
    pending.push_back(item);
    if (mode == bhpq_pkg::MODE_PUSH && planned_count < HEAP_SLOTS) planned_count++;
    if (mode == bhpq_pkg::MODE_POP && planned_count > 0) planned_count--;
  endtask

  task automatic queue_mix(int unsigned n, int unsigned push_pct, int unsigned pop_pct);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) queue_item(bhpq_pkg::MODE_PUSH, draw_key());
      else if (roll < push_pct + pop_pct) queue_item(bhpq_pkg::MODE_POP, draw_key());
      else if (roll < 98) queue_item(bhpq_pkg::MODE_PEEK, draw_key());
      else queue_item(MODE_UNUSED, draw_key());
    end
  endtask

  // Returns once every queued item has been answered and the block has settled.
  task automatic wait_idle();
    while (pending.size() != 0 || start || awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_order(bit to_max);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= to_max;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    max_first = to_max;
    n_orders++;
  endtask

  always @(posedge clk_i) begin : drive_requests
    request_t nxt;
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) awaited.push_back(predict_request(mode_i, key_value_i));
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          start       <= 1'b1;
          mode_i      <= nxt.mode;
          key_value_i <= nxt.key;
          gap_left    <= nxt.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && done_o) begin
      if (awaited.size() == 0) begin
        $error("unexpected result: top_value %h status %0d fill_count %0d",
               top_value_o, status_o, fill_count_o);
        failures++;
      end else begin
        want = awaited.pop_front();
        checked++;
        if (top_value_o !== want.top) begin
          $error("top_value expected %h got %h", want.top, top_value_o);
          failures++;
        end
        if (status_o !== want.sts) begin
          $error("status expected %0d got %0d", want.sts, status_o);
          failures++;
        end
        if (fill_count_o !== want.fill) begin
          $error("fill_count expected %0d got %0d", want.fill, fill_count_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("binary_heap_priority_queue regression: fail");
    $finish;
  end

  initial begin : run
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Min order out of reset: empty requests, the unused mode, ties and extremes.
    queue_item(bhpq_pkg::MODE_PEEK, '0);
    queue_item(bhpq_pkg::MODE_POP, '1);
    queue_item(MODE_UNUSED, '1);
    queue_item(bhpq_pkg::MODE_PUSH, 64'd5);
    queue_item(bhpq_pkg::MODE_PUSH, 64'd5);
    queue_item(bhpq_pkg::MODE_PUSH, '0);
    queue_item(bhpq_pkg::MODE_PUSH, '1);
    queue_item(bhpq_pkg::MODE_PUSH, {32{2'b10}});
    queue_item(bhpq_pkg::MODE_PUSH, {32{2'b01}});
    queue_item(bhpq_pkg::MODE_PUSH, 64'd5);
    queue_item(bhpq_pkg::MODE_PEEK, '0);
    queue_item(bhpq_pkg::MODE_POP, '0);
    queue_item(bhpq_pkg::MODE_POP, '0);
    queue_item(bhpq_pkg::MODE_POP, '0);
    wait_idle();

    // Flip to max order while keys are held; the store keeps its old layout.
    set_order(1'b1);
    queue_item(bhpq_pkg::MODE_PEEK, '0);
    queue_item(bhpq_pkg::MODE_PUSH, {1'b1, 63'd0});
    repeat (5) queue_item(bhpq_pkg::MODE_POP, '0);
    queue_item(bhpq_pkg::MODE_POP, '0);
    wait_idle();

    queue_mix(40, 55, 30);
    wait_idle();

    // Min order again with keys held, then fill to capacity and drain to empty.
    set_order(1'b0);
    while (planned_count < HEAP_SLOTS) queue_mix(1, 95, 2);
    repeat (3) queue_item(bhpq_pkg::MODE_PUSH, draw_key());
    while (planned_count != 0) queue_mix(1, 2, 95);
    repeat (2) queue_item(bhpq_pkg::MODE_POP, draw_key());
    wait_idle();

    set_order(1'b1);
    queue_mix(40, 50, 35);
    wait_idle();

    $display("%0d requests: %0d push, %0d pop, %0d peek, %0d unused mode",
             n_push + n_pop + n_peek + n_unused, n_push, n_pop, n_peek, n_unused);
    $display("%0d full and %0d empty rejections, %0d order writes, %0d results checked",
             n_full, n_empty, n_orders, checked);
    if (failures == 0) begin
      $display("binary_heap_priority_queue regression: pass");
    end else begin
      $display("binary_heap_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
